[rtl/cled_pkg.sv]
// Package for the console line editor with history.
// Holds key codes and command types shared by the front and back parts, and the back part's state type.
`default_nettype none
package cled_pkg;
    localparam int LINE_MAX_DEF      = 15;
    localparam int HISTORY_DEPTH_DEF = 8;
    localparam logic [7:0] PROMPT_RESET = 8'd36;

    localparam logic [7:0] KEY_CR  = 8'h0D;
    localparam logic [7:0] KEY_LF  = 8'h0A;
    localparam logic [7:0] KEY_BS  = 8'h08;
    localparam logic [7:0] KEY_DEL = 8'h7F;
    localparam logic [7:0] KEY_LFT = 8'h5B;
    localparam logic [7:0] KEY_RGT = 8'h5D;
    localparam logic [7:0] KEY_PRV = 8'h2C;
    localparam logic [7:0] KEY_NXT = 8'h2E;
    localparam logic [7:0] CH_SP   = 8'h20;

    typedef enum logic [2:0] {
        OP_ENTER, OP_BKSP, OP_LEFT, OP_RIGHT, OP_PREV, OP_NEXT, OP_INSERT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_ENT_LINE,
        ST_ENT_CR, ST_ENT_LF, ST_ENT_PR,
        ST_BS_SHIFT, ST_BS_ECHO, ST_BS_SP, ST_BS_BACK,
        ST_INS_SHIFT, ST_INS_ECHO, ST_INS_BACK,
        ST_ONE,
        ST_SAVE,
        ST_ERASE,
        ST_HLOAD_RD, ST_HLOAD,
        ST_SLOAD,
        ST_ECHO_LINE,
        ST_ENT_STORE
    } state_t;
endpackage
`default_nettype wire

[rtl/cled_if.sv]
// Valid/ready channel interface carrying the editor payloads.
// Depends on nothing.
`default_nettype none
interface cled_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       chunk_last;
    modport source (output valid, rx_byte, chunk_last, input ready);
    modport sink (input valid, rx_byte, chunk_last, output ready);
endinterface

interface cled_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_kind;
    logic [3:0] line_length;
    logic       last;
    modport source (output valid, out_byte, out_kind, line_length, last, input ready);
    modport sink (input valid, out_byte, out_kind, line_length, last, output ready);
endinterface
`default_nettype wire

[rtl/cled_ram.sv]
// Generic single-port-write, one-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module cled_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/cled_front.sv]
// Front part: accepts received bytes, classifies them into commands and
// queues them in a two-entry FIFO. Depends on cled_pkg and cled_if.
`default_nettype none
module cled_front (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cled_in_if.sink     rx,
    output logic        cmd_valid,
    output cled_pkg::cmd_t cmd,
    input  wire logic   cmd_pop
);
    cled_pkg::cmd_t q_reg [2];
    logic [1:0]     cnt_reg;
    logic           rd_reg;
    logic           wr_reg;
    cled_pkg::cmd_t cls;
    logic           push;

    // classify
    always_comb
    begin
        cls.data = rx.rx_byte;
        unique case (rx.rx_byte)
            cled_pkg::KEY_CR, cled_pkg::KEY_LF: cls.op = cled_pkg::OP_ENTER;
            cled_pkg::KEY_BS, cled_pkg::KEY_DEL: cls.op = cled_pkg::OP_BKSP;
            cled_pkg::KEY_LFT: cls.op = cled_pkg::OP_LEFT;
            cled_pkg::KEY_RGT: cls.op = cled_pkg::OP_RIGHT;
            cled_pkg::KEY_PRV: cls.op = cled_pkg::OP_PREV;
            cled_pkg::KEY_NXT: cls.op = cled_pkg::OP_NEXT;
            default: cls.op = cled_pkg::OP_INSERT;
        endcase
    end

    assign rx.ready  = (cnt_reg != 2'd2);
    assign push      = rx.valid && rx.ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= cls;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (cmd_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, cmd_pop};
        end
    end
endmodule
`default_nettype wire

[rtl/cled_back.sv]
// Back part: executes editor commands one at a time, walking the line,
// saved line and history RAM and emitting result bytes.
// Depends on cled_pkg, cled_if and cled_ram.
`default_nettype none
module cled_back #(
    parameter int LINE_MAX      = cled_pkg::LINE_MAX_DEF,
    parameter int HISTORY_DEPTH = cled_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic [7:0] prompt_char,
    input  wire logic      cmd_valid,
    input  cled_pkg::cmd_t cmd,
    output logic           cmd_pop,
    cled_out_if.source     tx
);
    localparam int SW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HA = SW + 4;
    localparam int HD = 16 << SW;
    localparam logic [SW-1:0] SLOT_TOP = SW'(HISTORY_DEPTH - 1);
    localparam logic [3:0] LMAX = 4'(LINE_MAX);

    // line and saved line registers (16 entries, fixed-place access per step)
    logic [7:0] line_reg [16];
    logic [7:0] saved_reg [16];
    logic [3:0] len_reg, cur_reg, slen_reg;
    logic [3:0] hlen_reg [HISTORY_DEPTH];
    logic [SW-1:0] newest_reg, browse_reg;
    logic hempty_reg, wrapped_reg, browsing_reg, atold_reg, atnew_reg;

    cled_pkg::state_t st_reg, st_next;
    cled_pkg::cmd_t   cmd_reg;
    logic [3:0] i_reg, i_next;
    logic [1:0] ph_reg, ph_next;

    // output register
    logic       ov_reg;
    logic [7:0] ob_reg;
    logic       ok_reg;
    logic [3:0] ol_reg;
    logic       olast_reg;

    // history RAM
    logic          h_we;
    logic [HA-1:0] h_waddr, h_raddr;
    logic [7:0]    h_wdata, h_rdata;

    cled_ram #(.WIDTH(8), .DEPTH(HD)) u_hist (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );

    logic out_free;
    assign out_free = !ov_reg || tx.ready;
    assign tx.valid       = ov_reg;
    assign tx.out_byte    = ob_reg;
    assign tx.out_kind    = ok_reg;
    assign tx.line_length = ol_reg;
    assign tx.last        = olast_reg;

    logic [SW-1:0] nslot;
    assign nslot = hempty_reg ? '0 : ((newest_reg == SLOT_TOP) ? '0 : newest_reg + 1'b1);
    logic [SW-1:0] wrap_next;
    assign wrap_next = (newest_reg == SLOT_TOP) ? '0 : newest_reg + 1'b1;

    // length of the line loaded after an erase
    logic [3:0] load_len;
    assign load_len = (cmd_reg.op == cled_pkg::OP_NEXT && atnew_reg) ? slen_reg
                                                                     : hlen_reg[browse_reg];

    assign h_waddr = {newest_reg, i_reg};
    assign h_wdata = line_reg[i_reg];
    assign h_we    = (st_reg == cled_pkg::ST_ENT_STORE);
    // read data is registered and lands in the next cycle, when i_reg has moved one past it
    assign h_raddr = {browse_reg, i_reg};

    // emission request from the control logic
    logic       em;
    logic [7:0] em_b;
    logic       em_k;
    logic       em_last;

    always_comb
    begin
        st_next = st_reg;
        i_next  = i_reg;
        ph_next = ph_reg;
        cmd_pop = 1'b0;
        em      = 1'b0;
        em_b    = 8'd0;
        em_k    = 1'b0;
        em_last = 1'b0;
        unique case (st_reg)
            cled_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    st_next = cled_pkg::ST_DECIDE;
                end
            end
            cled_pkg::ST_DECIDE:
            begin
                st_next = cled_pkg::ST_IDLE;
                i_next  = '0;
                unique case (cmd_reg.op)
                    cled_pkg::OP_ENTER:
                        st_next = (len_reg != 0) ? cled_pkg::ST_ENT_STORE
                                                 : cled_pkg::ST_ENT_CR;
                    cled_pkg::OP_BKSP:
                        if (cur_reg != 0)
                        begin
                            st_next = cled_pkg::ST_BS_SHIFT;
                            i_next  = cur_reg;
                        end
                    cled_pkg::OP_LEFT, cled_pkg::OP_RIGHT:
                        if ((cmd_reg.op == cled_pkg::OP_LEFT) ? (cur_reg != 0)
                                                              : (cur_reg < len_reg))
                        begin
                            st_next = cled_pkg::ST_ONE;
                        end
                    cled_pkg::OP_PREV:
                        if (!hempty_reg && !atold_reg)
                        begin
                            if (!browsing_reg)
                                st_next = cled_pkg::ST_SAVE;
                            else if (wrapped_reg ? (browse_reg == wrap_next)
                                                 : (browse_reg == '0))
                                st_next = cled_pkg::ST_IDLE;
                            else
                                st_next = cled_pkg::ST_ERASE;
                        end
                    cled_pkg::OP_NEXT:
                        if (!hempty_reg && !atnew_reg)
                        begin
                            st_next = cled_pkg::ST_ERASE;
                        end
                    default:
                        if (len_reg < LMAX)
                        begin
                            st_next = cled_pkg::ST_INS_SHIFT;
                            i_next  = len_reg;
                        end
                endcase
                ph_next = 2'd0;
            end
            cled_pkg::ST_ENT_STORE:
            begin
                if (i_reg == len_reg - 1'b1)
                begin
                    i_next  = '0;
                    st_next = cled_pkg::ST_ENT_LINE;
                end
                else
                    i_next = i_reg + 1'b1;
            end
            cled_pkg::ST_ENT_LINE:
                if (out_free)
                begin
                    em = 1'b1; em_k = 1'b1; em_b = line_reg[i_reg];
                    if (i_reg == len_reg - 1'b1)
                        st_next = cled_pkg::ST_ENT_CR;
                    else
                        i_next = i_reg + 1'b1;
                end
            cled_pkg::ST_ENT_CR:
                if (out_free)
                begin
                    em = 1'b1; em_b = cled_pkg::KEY_CR; st_next = cled_pkg::ST_ENT_LF;
                end
            cled_pkg::ST_ENT_LF:
                if (out_free)
                begin
                    em = 1'b1; em_b = cled_pkg::KEY_LF; st_next = cled_pkg::ST_ENT_PR;
                end
            cled_pkg::ST_ENT_PR:
                if (out_free)
                begin
                    em = 1'b1; em_b = prompt_char; em_last = 1'b1;
                    st_next = cled_pkg::ST_IDLE;
                end
            // shift tail left one byte at a time
            cled_pkg::ST_BS_SHIFT:
            begin
                if (i_reg >= len_reg)
                begin
                    st_next = cled_pkg::ST_BS_ECHO;
                    i_next  = cur_reg - 1'b1;
                    ph_next = 2'd1;
                end
                else
                    i_next = i_reg + 1'b1;
            end
            cled_pkg::ST_BS_ECHO:
                if (out_free)
                begin
                    em = 1'b1;
                    if (ph_reg == 2'd1)
                    begin
                        em_b = cled_pkg::KEY_BS; ph_next = 2'd0;
                        if (i_reg >= len_reg) st_next = cled_pkg::ST_BS_SP;
                    end
                    else
                    begin
                        em_b = line_reg[i_reg];
                        i_next = i_reg + 1'b1;
                        if (i_reg + 1'b1 >= len_reg) st_next = cled_pkg::ST_BS_SP;
                    end
                end
            cled_pkg::ST_BS_SP:
                if (out_free)
                begin
                    em = 1'b1; em_b = cled_pkg::CH_SP; i_next = cur_reg;
                    st_next = cled_pkg::ST_BS_BACK;
                end
            cled_pkg::ST_BS_BACK:
                if (out_free)
                begin
                    em = 1'b1; em_b = cled_pkg::KEY_BS;
                    if (i_reg >= len_reg)
                    begin
                        em_last = 1'b1; st_next = cled_pkg::ST_IDLE;
                    end
                    else
                        i_next = i_reg + 1'b1;
                end
            // open a gap at the cursor, one byte per cycle
            cled_pkg::ST_INS_SHIFT:
            begin
                if (i_reg <= cur_reg)
                begin
                    st_next = cled_pkg::ST_INS_ECHO;
                    i_next  = cur_reg;
                end
                else
                    i_next = i_reg - 1'b1;
            end
            cled_pkg::ST_INS_ECHO:
                if (out_free)
                begin
                    em = 1'b1; em_b = line_reg[i_reg];
                    if (i_reg + 1'b1 >= len_reg)
                    begin
                        i_next = cur_reg;
                        if (cur_reg >= len_reg)
                        begin
                            em_last = 1'b1; st_next = cled_pkg::ST_IDLE;
                        end
                        else
                            st_next = cled_pkg::ST_INS_BACK;
                    end
                    else
                        i_next = i_reg + 1'b1;
                end
            cled_pkg::ST_INS_BACK:
                if (out_free)
                begin
                    em = 1'b1; em_b = cled_pkg::KEY_BS;
                    if (i_reg + 1'b1 >= len_reg)
                    begin
                        em_last = 1'b1; st_next = cled_pkg::ST_IDLE;
                    end
                    else
                        i_next = i_reg + 1'b1;
                end
            cled_pkg::ST_ONE:
                if (out_free)
                begin
                    em = 1'b1; em_last = 1'b1;
                    em_b = (cmd_reg.op == cled_pkg::OP_LEFT) ? cled_pkg::KEY_BS
                                                             : line_reg[cur_reg];
                    st_next = cled_pkg::ST_IDLE;
                end
            cled_pkg::ST_SAVE:
                st_next = cled_pkg::ST_ERASE;
            // erase on screen: BS, space, BS per byte
            cled_pkg::ST_ERASE:
            begin
                if (i_reg >= len_reg)
                begin
                    i_next = '0;
                    if (cmd_reg.op == cled_pkg::OP_NEXT && atnew_reg)
                        st_next = cled_pkg::ST_SLOAD;
                    else
                        st_next = cled_pkg::ST_HLOAD_RD;
                end
                else if (out_free)
                begin
                    em = 1'b1;
                    em_b = (ph_reg == 2'd1) ? cled_pkg::CH_SP : cled_pkg::KEY_BS;
                    // final erase byte ends the key when an empty line follows
                    em_last = (ph_reg == 2'd2) && (i_reg + 1'b1 == len_reg)
                              && (load_len == 4'd0);
                    if (ph_reg == 2'd2)
                    begin
                        ph_next = 2'd0; i_next = i_reg + 1'b1;
                    end
                    else
                        ph_next = ph_reg + 1'b1;
                end
            end
            cled_pkg::ST_HLOAD_RD:
            begin
                st_next = cled_pkg::ST_HLOAD;
                i_next  = 4'd1;
            end
            cled_pkg::ST_HLOAD:
            begin
                if (i_reg >= len_reg)
                begin
                    i_next = '0; st_next = cled_pkg::ST_ECHO_LINE;
                end
                else
                    i_next = i_reg + 1'b1;
            end
            cled_pkg::ST_SLOAD:
                st_next = cled_pkg::ST_ECHO_LINE;
            cled_pkg::ST_ECHO_LINE:
            begin
                if (len_reg == 0)
                    st_next = cled_pkg::ST_IDLE;
                else if (out_free)
                begin
                    em = 1'b1; em_b = line_reg[i_reg];
                    if (i_reg + 1'b1 >= len_reg)
                    begin
                        em_last = 1'b1; st_next = cled_pkg::ST_IDLE;
                    end
                    else
                        i_next = i_reg + 1'b1;
                end
            end
            default: st_next = cled_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= cled_pkg::ST_IDLE;
            ov_reg       <= 1'b0;
            len_reg      <= '0;
            cur_reg      <= '0;
            slen_reg     <= '0;
            newest_reg   <= '0;
            browse_reg   <= '0;
            hempty_reg   <= 1'b1;
            wrapped_reg  <= 1'b0;
            browsing_reg <= 1'b0;
            atold_reg    <= 1'b0;
            atnew_reg    <= 1'b0;
            i_reg        <= '0;
            ph_reg       <= '0;
        end
        else
        begin
            st_reg <= st_next;
            i_reg  <= i_next;
            ph_reg <= ph_next;
            if (em)
                ov_reg <= 1'b1;
            else if (tx.ready)
                ov_reg <= 1'b0;
            if (st_reg == cled_pkg::ST_DECIDE)
            begin
                unique case (cmd_reg.op)
                    cled_pkg::OP_ENTER:
                        if (len_reg != 0)
                        begin
                            newest_reg <= nslot;
                            hempty_reg <= 1'b0;
                            if (!hempty_reg && newest_reg == SLOT_TOP)
                                wrapped_reg <= 1'b1;
                        end
                    cled_pkg::OP_PREV:
                        if (!hempty_reg && !atold_reg)
                        begin
                            atnew_reg <= 1'b0;
                            if (!browsing_reg)
                            begin
                                browsing_reg <= 1'b1;
                                slen_reg     <= len_reg;
                            end
                            else if (wrapped_reg ? (browse_reg == wrap_next)
                                                 : (browse_reg == '0))
                                atold_reg <= 1'b1;
                            else
                                browse_reg <= (browse_reg == '0) ? SLOT_TOP
                                                                 : browse_reg - 1'b1;
                        end
                    cled_pkg::OP_NEXT:
                        if (!hempty_reg && !atnew_reg)
                        begin
                            atold_reg <= 1'b0;
                            if (browse_reg == newest_reg)
                                atnew_reg <= 1'b1;
                            else
                                browse_reg <= (browse_reg == SLOT_TOP) ? '0
                                                                       : browse_reg + 1'b1;
                        end
                    default: ;
                endcase
            end
            // line / cursor bookkeeping at state transitions
            if (st_reg == cled_pkg::ST_ENT_LINE && st_next == cled_pkg::ST_ENT_CR)
            begin
                len_reg <= '0; cur_reg <= '0;
                browse_reg <= newest_reg;
                atold_reg <= 1'b0; atnew_reg <= 1'b1; browsing_reg <= 1'b0;
            end
            if (st_reg == cled_pkg::ST_BS_SHIFT && st_next == cled_pkg::ST_BS_ECHO)
            begin
                len_reg <= len_reg - 1'b1; cur_reg <= cur_reg - 1'b1;
            end
            if (st_reg == cled_pkg::ST_INS_SHIFT && st_next == cled_pkg::ST_INS_ECHO)
            begin
                len_reg <= len_reg + 1'b1; cur_reg <= cur_reg + 1'b1;
            end
            if (st_reg == cled_pkg::ST_ONE && em)
                cur_reg <= (cmd_reg.op == cled_pkg::OP_LEFT) ? cur_reg - 1'b1
                                                             : cur_reg + 1'b1;
            if (st_reg == cled_pkg::ST_HLOAD_RD)
            begin
                len_reg <= hlen_reg[browse_reg]; cur_reg <= hlen_reg[browse_reg];
            end
            if (st_reg == cled_pkg::ST_SLOAD)
            begin
                len_reg <= slen_reg; cur_reg <= slen_reg; browsing_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (st_reg == cled_pkg::ST_IDLE && cmd_pop)
            cmd_reg <= cmd;
        if (em)
        begin
            ob_reg    <= em_b;
            ok_reg    <= em_k;
            ol_reg    <= em_k ? len_reg : 4'd0;
            olast_reg <= em_last;
        end
        if (st_reg == cled_pkg::ST_ENT_STORE && i_reg == 4'd0)
            hlen_reg[newest_reg] <= len_reg;
        if (st_reg == cled_pkg::ST_BS_SHIFT && i_reg < len_reg)
            line_reg[i_reg - 1'b1] <= line_reg[i_reg];
        if (st_reg == cled_pkg::ST_INS_SHIFT)
        begin
            if (i_reg > cur_reg)
                line_reg[i_reg] <= line_reg[i_reg - 1'b1];
            else
                line_reg[cur_reg] <= cmd_reg.data;
        end
        if (st_reg == cled_pkg::ST_SAVE)
            saved_reg <= line_reg;
        if (st_reg == cled_pkg::ST_SLOAD)
            line_reg <= saved_reg;
        if (st_reg == cled_pkg::ST_HLOAD && i_reg != 4'd0)
            line_reg[i_reg - 1'b1] <= h_rdata;
    end
endmodule
`default_nettype wire

[rtl/console_line_editor_history.sv]
// Console line editor with history ring: top level.
// Depends on cled_pkg, cled_if, cled_front, cled_back and cled_ram.
`default_nettype none
// One received byte per transaction; each may cause up to about sixty result
// transactions, the final one marked last. The front part queues up to two
// classified keys while the back part works. The back part runs one key at a
// time: it takes the key in ST_IDLE and decodes it in ST_DECIDE, shifts bytes
// in the line or stores them to or loads them from the history RAM at one byte
// per cycle, emits one byte per cycle while the output is taken, and passes
// through ST_SAVE, ST_HLOAD_RD or ST_SLOAD around a history or saved-line load.
// Prompt writes must happen while the block is idle.
module console_line_editor_history #(
    parameter int LINE_MAX      = cled_pkg::LINE_MAX_DEF,
    parameter int HISTORY_DEPTH = cled_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [7:0] cfg_wdata,
    cled_in_if.sink   rx,
    cled_out_if.source tx
);
    logic [7:0]     prompt_reg;
    logic           cmd_valid;
    logic           cmd_pop;
    cled_pkg::cmd_t cmd;

    // prompt register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prompt_reg <= cled_pkg::PROMPT_RESET;
        else if (cfg_we)
            prompt_reg <= cfg_wdata;
    end

    cled_front u_front (
        .clk(clk), .rst_n(rst_n), .rx(rx),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
    );

    cled_back #(.LINE_MAX(LINE_MAX), .HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .prompt_char(prompt_reg),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop), .tx(tx)
    );

    // a pop needs a queued command
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid) else $error("pop from empty queue");
    // line output carries a nonzero length
    a_line_len: assert property (@(posedge clk) disable iff (!rst_n)
        (tx.valid && tx.out_kind) |-> (tx.line_length != 4'd0))
        else $error("line byte with zero length");
    // echo bytes carry zero length
    a_echo_len: assert property (@(posedge clk) disable iff (!rst_n)
        (tx.valid && !tx.out_kind) |-> (tx.line_length == 4'd0))
        else $error("echo byte with length");
endmodule
`default_nettype wire
